[rtl/tdpt_pkg.sv]
// Package for the trial-division prime test core.
// Holds the prime counter width, its saturation limit and the counter type.
// No dependencies.
`default_nettype none

package tdpt_pkg;

	localparam int COUNT_BITS = 17;

	typedef logic [COUNT_BITS-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

endpackage

`default_nettype wire

[rtl/trial_division_prime_test_core.sv]
// Top level of the trial-division prime test core: control sequencer, prime table memory
// and a shared bit-serial remainder unit.
// Depends on tdpt_pkg for the prime counter type and its limit.
//
// Channel      Signals                               Handshake
// command      start, candidate                      taken when start is high and busy is low
// result       done, is_prime, prime_count,          one-cycle strobe on done, never held off
//              table_full
//
// Candidates below three and even ones go straight to the result. An odd candidate is divided
// by the stored primes in table order: each division reads the table, squares the prime, checks
// the square against the candidate and forms the remainder bit-serially over VALUE_BITS bits.
// It is composite when a prime divides it, else prime and stored if the table has room.
// Reset clears the counters and the sequencer; the table stays undefined and only written
// entries are read. The receiver cannot stall, and the done cycle can take a new transaction.
`default_nettype none

module trial_division_prime_test_core #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_BITS  = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [VALUE_BITS-1:0]          candidate,
	output logic                                done,
	output logic                                is_prime,
	output logic [tdpt_pkg::COUNT_BITS-1:0]     prime_count,
	output logic                                table_full
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int BW  = $clog2(VALUE_BITS);
	localparam int SQW = 2 * VALUE_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_CHECK,
		ST_DIVIDE,
		ST_STORE,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   cand_q;
	logic [AW:0]             idx_q;
	logic [AW:0]             stored_q;
	logic [VALUE_BITS-1:0]   div_q;
	logic [SQW-1:0]          sq_q;
	logic [VALUE_BITS-1:0]   rem_q;
	logic [BW-1:0]           bit_q;
	logic                    prime_q;
	tdpt_pkg::count_t        count_q;
	logic                    done_q;
	logic                    is_prime_q;
	logic                    table_full_q;

	logic [VALUE_BITS-1:0]   prime_table [TABLE_DEPTH];
	logic [VALUE_BITS-1:0]   rd_data_q;
	logic                    mem_we;
	logic                    mem_re;

	logic [VALUE_BITS:0]     rem_shift;
	logic [VALUE_BITS:0]     rem_next;
	logic                    full_now;

	assign full_now  = (stored_q == (AW+1)'(TABLE_DEPTH));
	assign mem_we    = (state_q == ST_STORE) && !full_now;
	assign mem_re    = (state_q == ST_READ) && (idx_q < stored_q);
	assign rem_shift = {rem_q, cand_q[bit_q]};
	assign rem_next  = (rem_shift >= {1'b0, div_q}) ? (rem_shift - {1'b0, div_q}) : rem_shift;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			prime_table[stored_q[AW-1:0]] <= cand_q;
		end
		if (mem_re) begin
			rd_data_q <= prime_table[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cand_q       <= '0;
			idx_q        <= '0;
			stored_q     <= '0;
			div_q        <= '0;
			sq_q         <= '0;
			rem_q        <= '0;
			bit_q        <= '0;
			prime_q      <= 1'b0;
			count_q      <= '0;
			done_q       <= 1'b0;
			is_prime_q   <= 1'b0;
			table_full_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cand_q <= candidate;
						idx_q  <= '0;
						if (candidate == VALUE_BITS'(2)) begin
							prime_q <= 1'b1;
							state_q <= ST_FINISH;
						end else if (candidate < VALUE_BITS'(3) || !candidate[0]) begin
							prime_q <= 1'b0;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (idx_q < stored_q) begin
						state_q <= ST_SQUARE;
					end else begin
						prime_q <= 1'b1;
						state_q <= ST_STORE;
					end
				end
				ST_SQUARE: begin
					div_q   <= rd_data_q;
					sq_q    <= SQW'(rd_data_q) * SQW'(rd_data_q);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (sq_q > SQW'(cand_q)) begin
						prime_q <= 1'b1;
						state_q <= ST_STORE;
					end else begin
						rem_q   <= '0;
						bit_q   <= BW'(VALUE_BITS - 1);
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					rem_q <= rem_next[VALUE_BITS-1:0];
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						if (rem_next == '0) begin
							prime_q <= 1'b0;
							state_q <= ST_FINISH;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_STORE: begin
					if (!full_now) begin
						stored_q <= stored_q + 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (prime_q && count_q != tdpt_pkg::COUNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
					done_q       <= 1'b1;
					is_prime_q   <= prime_q;
					table_full_q <= full_now;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign is_prime    = is_prime_q;
	assign prime_count = count_q;
	assign table_full  = table_full_q;

endmodule

`default_nettype wire

[bench/prime_result_checker.sv]
// Result checker for the trial-division prime test core testbench.
// Watches the command and result channels, predicts every result and compares it.
// Depends on tdpt_pkg for the prime counter type and its saturation limit.
module prime_result_checker #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_BITS  = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [VALUE_BITS-1:0] candidate,
	input  logic                  done,
	input  logic                  is_prime,
	input  tdpt_pkg::count_t      prime_count,
	input  logic                  table_full,
	output int                    error_count,
	output int                    pending
);

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		logic                  prime;
		tdpt_pkg::count_t      count;
		logic                  full;
	} verdict_t;

	verdict_t              awaited[$];
	verdict_t              head;
	logic [VALUE_BITS-1:0] stored_values [TABLE_DEPTH];
	int                    stored_used;
	tdpt_pkg::count_t      primes_found;

	initial begin
		error_count = 0;
		pending = 0;
		stored_used = 0;
		primes_found = '0;
	end

	task automatic report_mismatch(input string what);
		if (error_count < 50)
			$display("%0t mismatch: %s", $time, what);
		error_count++;
	endtask

	// Trial division by the stored primes in table order, stopping once the
	// square of a stored prime passes the value.
	function automatic logic survives_division(input logic [VALUE_BITS-1:0] value);
		longint unsigned divisor;
		for (int j = 0; j < stored_used; j++) begin
			divisor = stored_values[j];
			if (divisor == 0 || divisor * divisor > value)
				return 1'b1;
			if (value % divisor == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic predict_verdict(input logic [VALUE_BITS-1:0] value);
		verdict_t v;
		v.value = value;
		if (value < 2)
			v.prime = 1'b0;
		else if (value == 2)
			v.prime = 1'b1;
		else if (!value[0])
			v.prime = 1'b0;
		else begin
			v.prime = survives_division(value);
			if (v.prime && stored_used < TABLE_DEPTH) begin
				stored_values[stored_used] = value;
				stored_used++;
			end
		end
		if (v.prime && primes_found != tdpt_pkg::COUNT_MAX)
			primes_found++;
		v.count = primes_found;
		v.full = (stored_used >= TABLE_DEPTH);
		awaited.push_back(v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_used = 0;
			primes_found = '0;
			awaited.delete();
		end else begin
			if (done) begin
				if (awaited.size() == 0)
					report_mismatch("result with no transaction outstanding");
				else begin
					head = awaited.pop_front();
					if (head.prime !== is_prime || head.count !== prime_count
							|| head.full !== table_full)
						report_mismatch($sformatf(
							"candidate %0d: got prime %b count %0d full %b, want %b %0d %b",
							head.value, is_prime, prime_count, table_full,
							head.prime, head.count, head.full));
				end
			end
			if (start && !busy)
				predict_verdict(candidate);
		end
		pending <= awaited.size();
	end

endmodule

[bench/trial_division_prime_test_core_test.sv]
// Testbench top for the trial-division prime test core: clock, reset and candidate stimulus.
// Depends on tdpt_pkg, the core and prime_result_checker, which predicts and compares results.
module trial_division_prime_test_core_test;

	localparam int TABLE_DEPTH = 256;
	localparam int VALUE_BITS  = 20;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [VALUE_BITS-1:0] candidate = '0;
	logic                  busy;
	logic                  done;
	logic                  is_prime;
	logic                  table_full;
	tdpt_pkg::count_t      prime_count;
	int                    error_count;
	int                    pending;
	int                    burst_left = 0;
	int                    burst_max = 40;
	int                    gap_max = 30;
	logic [VALUE_BITS-1:0] next_odd;
	logic [VALUE_BITS-1:0] opening [17] = '{0, 1, 2, 4, VALUE_MAX - 1, 3, VALUE_MAX, 5, 7, 7,
		9, 11, 13, 9, 15, 2, 17};

	trial_division_prime_test_core #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.candidate(candidate),
		.done(done),
		.is_prime(is_prime),
		.prime_count(prime_count),
		.table_full(table_full)
	);

	prime_result_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.candidate(candidate),
		.done(done),
		.is_prime(is_prime),
		.prime_count(prime_count),
		.table_full(table_full),
		.error_count(error_count),
		.pending(pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Presents one candidate and returns at the falling edge after the transaction.
	task automatic send(input logic [VALUE_BITS-1:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(0, gap_max);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, burst_max);
		end
		start <= 1'b1;
		candidate <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	initial begin
		int pick;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send(opening[i]);

		// Mostly the ascending odd sequence, with harmless noise, repeats of recent
		// values and, once the table is full, odd values from the whole range.
		next_odd = 19;
		repeat (1500) begin
			pick = $urandom_range(0, 99);
			if (pick < 82) begin
				send(next_odd);
				next_odd += 2;
			end else if (pick < 88) begin
				case ($urandom_range(0, 3))
					0: send(0);
					1: send(1);
					2: send(2);
					default: send(VALUE_BITS'($urandom) & ~VALUE_BITS'(1));
				endcase
			end else if (pick < 92)
				send(next_odd - VALUE_BITS'(2 * $urandom_range(1, 4)));
			else if (next_odd > 1800)
				send(($urandom_range(0, 3) == 0) ? VALUE_MAX - 2
					: (VALUE_BITS'($urandom) | VALUE_BITS'(1)));
			else begin
				send(next_odd);
				next_odd += 2;
			end
		end

		send(2);
		send(VALUE_MAX - 2);
		send(VALUE_MAX);
		send(0);
		repeat (6) begin
			send(next_odd);
			next_odd += 2;
		end
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (error_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
